// File: rtl/core/masked_sprite_blitter_1bpp_top_defines.svh
// assertion macros shared by the blitter rtl
`ifndef MASKED_SPRITE_BLITTER_1BPP_TOP_DEFINES_SVH
`define MASKED_SPRITE_BLITTER_1BPP_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// condition that holds at every clock edge out of reset
`define MSB_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// condition that holds in the cycle after a trigger
`define MSB_ASSERT_NXT(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) else $error(msg);
`else
`define MSB_ASSERT(lbl, cond, msg)
`define MSB_ASSERT_NXT(lbl, trig, cond, msg)
`endif

`endif

// File: rtl/core/msb_pkg.sv
package msb_pkg;

  // fixed field widths
  localparam int WORD_W  = 16;
  localparam int CMD_W   = 2;
  localparam int SLOT_W  = 4;
  localparam int ADDR_W  = 13;
  localparam int X_W     = 9;
  localparam int Y_W     = 8;
  localparam int SHIFT_W = 4;

  // command codes
  localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DRAW  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [SLOT_W-1:0] sprite_slot;
    logic [ADDR_W-1:0] word_address;
    logic [WORD_W-1:0] alpha_word;
    logic [WORD_W-1:0] color_word;
    logic              fill_color;
    logic [X_W-1:0]    pos_x;
    logic [Y_W-1:0]    pos_y;
  } in_item_t;

  typedef struct packed {
    logic [WORD_W-1:0] read_data;
    logic              data_valid;
  } out_item_t;

endpackage

// File: rtl/core/msb_ram.sv
module msb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/masked_sprite_blitter_1bpp_top.sv
// 1bpp masked sprite blitter
// input channel: in_data is taken when start is high and busy is low; cmd selects
// load sprite word, clear framebuffer, draw sprite at (pos_x, pos_y) or read word.
// result channel: every command gives one result on out_data, marked by a one-cycle
// out_valid strobe; the receiver cannot stall, so no result ever waits.
// busy stays high from the transfer until the cycle of the strobe, in which a new
// command may already be taken.
// steps from transfer to strobe:
//   load  : S_LOAD writes the sprite word
//   read  : S_READ addresses the framebuffer, S_READ_OUT registers the word
//   clear : S_CLEAR, one framebuffer word written per cycle
//   draw  : per sprite word S_DRAW_RD, S_DRAW_M0 and, if pos_x is not a multiple of
//           16, S_DRAW_M1; each sprite word is a sprite read plus a read-modify-write
//           of one or two framebuffer words through the single framebuffer write port
//   draw from a slot number of SPRITE_SLOTS or more: S_ACK only
// the framebuffer and sprite memories are not initialized by reset; a clear must
// come before reads or draws. reset only returns the sequencer to idle and drops out_valid.
`include "masked_sprite_blitter_1bpp_top_defines.svh"

module masked_sprite_blitter_1bpp_top #(
  parameter int SPRITE_SLOTS   = 16,
  parameter int SPRITE_WORDS_X = 2,
  parameter int SPRITE_LINES   = 32,
  parameter int FB_WORDS_X     = 32,
  parameter int FB_LINES       = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  msb_pkg::in_item_t  in_data,
  output logic               out_valid,
  output msb_pkg::out_item_t out_data
);

  localparam int WW        = msb_pkg::WORD_W;
  localparam int SPR_WORDS = SPRITE_WORDS_X * SPRITE_LINES;
  localparam int SPR_TOTAL = SPRITE_SLOTS * SPR_WORDS;
  localparam int FB_TOTAL  = FB_WORDS_X * FB_LINES;
  localparam int SPR_AW    = (SPR_TOTAL > 1) ? $clog2(SPR_TOTAL) : 1;
  localparam int FB_AW     = (FB_TOTAL > 1) ? $clog2(FB_TOTAL) : 1;
  localparam int LINE_W    = (SPRITE_LINES > 1) ? $clog2(SPRITE_LINES) : 1;
  localparam int COL_W     = (SPRITE_WORDS_X > 1) ? $clog2(SPRITE_WORDS_X) : 1;
  // upper bound on the linear addresses a draw can reach
  localparam int FA_MAX    = ((1 << msb_pkg::Y_W) - 1) * FB_WORDS_X
                           + ((1 << msb_pkg::X_W) - 1) / (1 << msb_pkg::SHIFT_W)
                           + SPRITE_LINES * FB_WORDS_X + SPRITE_WORDS_X;
  localparam int FA_TOP    = (FA_MAX > FB_TOTAL) ? FA_MAX : FB_TOTAL;
  localparam int FA_W      = $clog2(FA_TOP + 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOAD,
    S_CLEAR,
    S_DRAW_RD,
    S_DRAW_M0,
    S_DRAW_M1,
    S_READ,
    S_READ_OUT,
    S_ACK
  } state_t;

  state_t             state_r;
  msb_pkg::in_item_t  in_r;
  msb_pkg::out_item_t out_data_r;
  logic               out_valid_r;
  logic               out_valid_nxt;
  logic [FB_AW-1:0]   clr_r;
  logic [FA_W-1:0]    fa_line_r;
  logic [SPR_AW-1:0]  sa_r;
  logic [COL_W-1:0]   col_r;
  logic [LINE_W-1:0]  line_r;
  logic [WW-1:0]      spill_a_r;
  logic [WW-1:0]      spill_c_r;

  logic               spr_we;
  logic [SPR_AW-1:0]  spr_waddr;
  logic [SPR_AW-1:0]  spr_raddr;
  logic [2*WW-1:0]    spr_q;
  logic               fb_we;
  logic [FA_W-1:0]    fb_wlin;
  logic [FB_AW-1:0]   fb_waddr;
  logic [WW-1:0]      fb_wdata;
  logic [FB_AW-1:0]   fb_raddr;
  logic [WW-1:0]      fb_q;

  logic [FA_W-1:0]    fa0;
  logic [FA_W-1:0]    fa1;
  logic [2*WW-1:0]    sh_a;
  logic [2*WW-1:0]    sh_c;
  logic [31:0]        load_lin;
  logic [31:0]        rd_lin;
  logic               load_ok;
  logic               rd_ok;
  logic               wlin_ok;
  logic               last_col;
  logic               last_line;
  logic               word_done;

  function automatic logic [WW-1:0] merge(input logic [WW-1:0] fb,
                                          input logic [WW-1:0] a,
                                          input logic [WW-1:0] c);
    merge = (fb & ~a) | (c & a);
  endfunction

  // sprite memory holds {alpha, color}
  msb_ram #(.WIDTH(2*WW), .DEPTH(SPR_TOTAL)) u_spr_ram (
    .clk   (clk),
    .we    (spr_we),
    .waddr (spr_waddr),
    .wdata ({in_r.alpha_word, in_r.color_word}),
    .raddr (spr_raddr),
    .rdata (spr_q)
  );

  msb_ram #(.WIDTH(WW), .DEPTH(FB_TOTAL)) u_fb_ram (
    .clk   (clk),
    .we    (fb_we),
    .waddr (fb_waddr),
    .wdata (fb_wdata),
    .raddr (fb_raddr),
    .rdata (fb_q)
  );

  // address checks for load and read
  assign load_lin  = 32'(in_r.sprite_slot) * 32'(SPR_WORDS) + 32'(in_r.word_address);
  assign load_ok   = (32'(in_r.sprite_slot) < 32'(SPRITE_SLOTS))
                  && (32'(in_r.word_address) < 32'(SPR_WORDS));
  assign rd_lin    = 32'(in_r.word_address);
  assign rd_ok     = rd_lin < 32'(FB_TOTAL);
  assign spr_waddr = load_lin[SPR_AW-1:0];

  // draw position within the sprite
  assign fa0       = fa_line_r + FA_W'(col_r);
  assign fa1       = fa0 + FA_W'(1);
  assign last_col  = col_r == COL_W'(SPRITE_WORDS_X - 1);
  assign last_line = line_r == LINE_W'(SPRITE_LINES - 1);
  assign word_done = (state_r == S_DRAW_M1)
                  || ((state_r == S_DRAW_M0) && (in_r.pos_x[msb_pkg::SHIFT_W-1:0] == '0));

  // alpha and color shifters: upper half lands in the first word, lower half spills
  assign sh_a = {spr_q[2*WW-1:WW], {WW{1'b0}}} >> in_r.pos_x[msb_pkg::SHIFT_W-1:0];
  assign sh_c = {spr_q[WW-1:0], {WW{1'b0}}} >> in_r.pos_x[msb_pkg::SHIFT_W-1:0];

  // result strobe in the cycle after the last step of a command
  assign out_valid_nxt = (state_r == S_LOAD) || (state_r == S_ACK)
                      || (state_r == S_READ_OUT)
                      || ((state_r == S_CLEAR) && (clr_r == FB_AW'(FB_TOTAL - 1)))
                      || (word_done && last_col && last_line);

  // memory port control
  always_comb begin
    spr_we    = 1'b0;
    spr_raddr = sa_r;
    fb_we     = 1'b0;
    fb_wlin   = fa0;
    fb_wdata  = '0;
    fb_raddr  = fa0[FB_AW-1:0];
    unique case (state_r)
      S_LOAD: begin
        spr_we = load_ok;
      end
      S_CLEAR: begin
        fb_we    = 1'b1;
        fb_wlin  = FA_W'(clr_r);
        fb_wdata = {WW{in_r.fill_color}};
      end
      S_DRAW_RD: begin
        fb_raddr = fa0[FB_AW-1:0];
      end
      S_DRAW_M0: begin
        fb_we    = 1'b1;
        fb_wlin  = fa0;
        fb_wdata = merge(fb_q, sh_a[2*WW-1:WW], sh_c[2*WW-1:WW]);
        fb_raddr = fa1[FB_AW-1:0];
      end
      S_DRAW_M1: begin
        fb_we    = 1'b1;
        fb_wlin  = fa1;
        fb_wdata = merge(fb_q, spill_a_r, spill_c_r);
      end
      S_READ: begin
        fb_raddr = rd_lin[FB_AW-1:0];
      end
      default: begin
      end
    endcase
    // words past the buffer end are dropped
    wlin_ok  = 32'(fb_wlin) < 32'(FB_TOTAL);
    fb_we    = fb_we && wlin_ok;
    fb_waddr = fb_wlin[FB_AW-1:0];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            in_r      <= in_data;
            clr_r     <= '0;
            col_r     <= '0;
            line_r    <= '0;
            fa_line_r <= FA_W'(32'(in_data.pos_y) * 32'(FB_WORDS_X)
                         + 32'(in_data.pos_x >> msb_pkg::SHIFT_W));
            sa_r      <= SPR_AW'(32'(in_data.sprite_slot) * 32'(SPR_WORDS));
            unique case (in_data.cmd)
              msb_pkg::CMD_LOAD:  state_r <= S_LOAD;
              msb_pkg::CMD_CLEAR: state_r <= S_CLEAR;
              msb_pkg::CMD_DRAW: begin
                if (32'(in_data.sprite_slot) < 32'(SPRITE_SLOTS)) begin
                  state_r <= S_DRAW_RD;
                end else begin
                  state_r <= S_ACK;
                end
              end
              msb_pkg::CMD_READ:  state_r <= S_READ;
            endcase
          end
        end
        S_LOAD, S_ACK: begin
          out_data_r  <= '0;
          state_r     <= S_IDLE;
        end
        S_CLEAR: begin
          clr_r <= clr_r + FB_AW'(1);
          if (clr_r == FB_AW'(FB_TOTAL - 1)) begin
            out_data_r  <= '0;
            state_r     <= S_IDLE;
          end
        end
        S_DRAW_RD: begin
          state_r <= S_DRAW_M0;
        end
        S_DRAW_M0: begin
          spill_a_r <= sh_a[WW-1:0];
          spill_c_r <= sh_c[WW-1:0];
          if (!word_done) begin
            state_r <= S_DRAW_M1;
          end
        end
        S_DRAW_M1: begin
        end
        S_READ: begin
          state_r <= S_READ_OUT;
        end
        S_READ_OUT: begin
          out_data_r.read_data  <= rd_ok ? fb_q : '0;
          out_data_r.data_valid <= rd_ok;
          state_r              <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
      // step to the next sprite word
      if (word_done) begin
        sa_r <= sa_r + SPR_AW'(1);
        if (last_col) begin
          col_r     <= '0;
          line_r    <= line_r + LINE_W'(1);
          fa_line_r <= fa_line_r + FA_W'(FB_WORDS_X);
        end else begin
          col_r <= col_r + COL_W'(1);
        end
        if (last_col && last_line) begin
          out_data_r  <= '0;
          state_r     <= S_IDLE;
        end else begin
          state_r <= S_DRAW_RD;
        end
      end
    end
  end

  assign busy      = state_r != S_IDLE;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // checks
  `MSB_ASSERT(a_strobe_idle, !out_valid_r || state_r == S_IDLE, "result strobe while busy")
  `MSB_ASSERT_NXT(a_take_busy, start && !busy, busy, "command transfer did not raise busy")
  `MSB_ASSERT(a_nonread_zero, !out_valid_r || out_data_r.data_valid || out_data_r.read_data == '0,
    "nonzero read_data without data_valid")
  `MSB_ASSERT(a_fb_range, !fb_we || 32'(fb_wlin) < 32'(FB_TOTAL), "framebuffer write past end")
  `MSB_ASSERT(a_draw_slot, state_r != S_DRAW_RD || 32'(in_r.sprite_slot) < 32'(SPRITE_SLOTS),
    "draw from slot out of range")

endmodule

// File: sim/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import msb_pkg::*;

  // block geometry, kept equal to the instance parameters
  localparam int unsigned SLOTS       = 16;
  localparam int unsigned SPR_WX      = 2;
  localparam int unsigned SPR_LINES   = 32;
  localparam int unsigned FB_WX       = 32;
  localparam int unsigned FB_LINES    = 256;
  localparam int unsigned SPR_WORDS   = SPR_WX * SPR_LINES;
  localparam int unsigned SPR_TOTAL   = SLOTS * SPR_WORDS;
  localparam int unsigned FB_TOTAL    = FB_WX * FB_LINES;

  // run shaping
  localparam int unsigned RANDOM_ITEMS = 1100;
  localparam int unsigned PHASE_LEN    = 110;
  localparam int unsigned STALL_LIMIT  = 4 * FB_TOTAL + 8000;
  localparam int unsigned SETTLE_CYCLES = 300;
  localparam int unsigned IDLE_PCT [3] = '{0, 54, 9};

  typedef struct {
    in_item_t    item;
    bit          wait_drain;
    int unsigned idle_pct;
  } blit_request_t;

  logic      clk;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  in_item_t  in_data = '0;
  logic      busy;
  logic      out_valid;
  out_item_t out_data;

  // pending commands and results still owed by the block
  blit_request_t blit_requests [$];
  out_item_t     expected_replies [$];

  // shadow of the block's memories
  logic [WORD_W-1:0] frame_model [FB_TOTAL];
  logic [WORD_W-1:0] sprite_alpha_model [SPR_TOTAL];
  logic [WORD_W-1:0] sprite_color_model [SPR_TOTAL];

  // generator bookkeeping: which sprite words hold defined data
  bit          word_loaded [SPR_TOTAL];
  int unsigned gen_count;
  int unsigned gen_idle_pct;

  logic        in_taken = 1'b0;
  int unsigned idle_cycles = 0;
  int unsigned error_count = 0;
  int unsigned results_checked = 0;
  int unsigned cmd_count [4] = '{0, 0, 0, 0};

  masked_sprite_blitter_1bpp_top #(
    .SPRITE_SLOTS  (SLOTS),
    .SPRITE_WORDS_X(SPR_WX),
    .SPRITE_LINES  (SPR_LINES),
    .FB_WORDS_X    (FB_WX),
    .FB_LINES      (FB_LINES)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  task automatic report_mismatch(string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  // masked merge of one framebuffer word, dropped past the buffer end
  function automatic void merge_frame_word(int unsigned addr, logic [WORD_W-1:0] a,
                                           logic [WORD_W-1:0] c);
    if (addr < FB_TOTAL) frame_model[addr] = (frame_model[addr] & ~a) | (c & a);
  endfunction

  // predict the result of one command and update the shadow memories
  function automatic out_item_t predict_blit(in_item_t it);
    out_item_t         res;
    int unsigned       sh;
    int unsigned       base;
    int unsigned       fa;
    int unsigned       si;
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] c;
    logic [WORD_W-1:0] a_hi;
    logic [WORD_W-1:0] c_hi;
    logic [WORD_W-1:0] a_lo;
    logic [WORD_W-1:0] c_lo;
    res = '0;
    case (it.cmd)
      CMD_LOAD: begin
        if (it.sprite_slot < SLOTS && it.word_address < SPR_WORDS) begin
          si = it.sprite_slot * SPR_WORDS + it.word_address;
          sprite_alpha_model[si] = it.alpha_word;
          sprite_color_model[si] = it.color_word;
        end
      end
      CMD_CLEAR: begin
        for (int unsigned i = 0; i < FB_TOTAL; i++) frame_model[i] = {WORD_W{it.fill_color}};
      end
      CMD_DRAW: begin
        if (it.sprite_slot < SLOTS) begin
          sh   = 32'(it.pos_x[SHIFT_W-1:0]);
          base = it.pos_y * FB_WX + (it.pos_x >> SHIFT_W);
          for (int unsigned line = 0; line < SPR_LINES; line++) begin
            fa = base + line * FB_WX;
            for (int unsigned col = 0; col < SPR_WX; col++) begin
              si   = it.sprite_slot * SPR_WORDS + line * SPR_WX + col;
              a    = sprite_alpha_model[si];
              c    = sprite_color_model[si];
              a_hi = a >> sh;
              c_hi = c >> sh;
              merge_frame_word(fa + col, a_hi, c_hi);
              // spill of the shifted-out pixels into the next word
              if (sh != 0) begin
                a_lo = a << (WORD_W - sh);
                c_lo = c << (WORD_W - sh);
                merge_frame_word(fa + col + 1, a_lo, c_lo);
              end
            end
          end
        end
      end
      CMD_READ: begin
        if (it.word_address < FB_TOTAL) begin
          res.read_data  = frame_model[it.word_address];
          res.data_valid = 1'b1;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // stimulus helpers
  function automatic in_item_t random_fields();
    in_item_t it;
    it.cmd          = CMD_W'($urandom_range(3));
    it.sprite_slot  = SLOT_W'($urandom_range(SLOTS - 1));
    it.word_address = ADDR_W'($urandom_range(FB_TOTAL - 1));
    it.alpha_word   = WORD_W'($urandom);
    it.color_word   = WORD_W'($urandom);
    it.fill_color   = 1'($urandom_range(1));
    it.pos_x        = X_W'($urandom_range(511));
    it.pos_y        = Y_W'($urandom_range(255));
    return it;
  endfunction

  task automatic queue_cmd(in_item_t it, bit drain = 1'b0);
    blit_request_t req;
    req.item       = it;
    req.wait_drain = drain;
    req.idle_pct   = gen_idle_pct;
    blit_requests.push_back(req);
    // loads with an out-of-range word address write nothing in the block and are not counted
    if (it.cmd == CMD_LOAD) begin
      if (it.word_address < SPR_WORDS) begin
        word_loaded[it.sprite_slot * SPR_WORDS + it.word_address] = 1'b1;
        gen_count++;
      end
    end else begin
      gen_count++;
    end
  endtask

  task automatic queue_load(int unsigned slot, int unsigned waddr, logic [WORD_W-1:0] a,
                            logic [WORD_W-1:0] c);
    in_item_t it;
    it              = random_fields();
    it.cmd          = CMD_LOAD;
    it.sprite_slot  = SLOT_W'(slot);
    it.word_address = ADDR_W'(waddr);
    it.alpha_word   = a;
    it.color_word   = c;
    queue_cmd(it);
  endtask

  task automatic queue_clear(bit fill, bit drain);
    in_item_t it;
    it            = random_fields();
    it.cmd        = CMD_CLEAR;
    it.fill_color = fill;
    queue_cmd(it, drain);
  endtask

  task automatic queue_draw(int unsigned slot, int unsigned x, int unsigned y);
    in_item_t it;
    it             = random_fields();
    it.cmd         = CMD_DRAW;
    it.sprite_slot = SLOT_W'(slot);
    it.pos_x       = X_W'(x);
    it.pos_y       = Y_W'(y);
    queue_cmd(it);
  endtask

  task automatic queue_read(int unsigned addr, bit drain = 1'b0);
    in_item_t it;
    it              = random_fields();
    it.cmd          = CMD_READ;
    it.word_address = ADDR_W'(addr % FB_TOTAL);
    queue_cmd(it, drain);
  endtask

  // load every word of one slot, in ascending or descending order
  task automatic queue_slot_fill(int unsigned slot);
    int unsigned       mode;
    int unsigned       w;
    bit                descending;
    logic [WORD_W-1:0] a;
    mode       = $urandom_range(3);
    descending = 1'($urandom_range(1));
    for (int unsigned k = 0; k < SPR_WORDS; k++) begin
      w = descending ? SPR_WORDS - 1 - k : k;
      a = WORD_W'($urandom);
      case (mode)
        0:       a = '1;
        1:       a = a & WORD_W'($urandom);
        default: ;
      endcase
      queue_load(slot, w, a, WORD_W'($urandom));
    end
  endtask

  function automatic bit slot_ready(int unsigned slot);
    for (int unsigned w = 0; w < SPR_WORDS; w++)
      if (!word_loaded[slot * SPR_WORDS + w]) return 1'b0;
    return 1'b1;
  endfunction

  // driver: next command goes out at the falling edge once the last one transferred
  always @(negedge clk) begin : driver
    blit_request_t head;
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!start || in_taken) begin
      if (blit_requests.size() != 0) begin
        head = blit_requests[0];
        if ((head.wait_drain && expected_replies.size() != 0) ||
            $urandom_range(99) < head.idle_pct) begin
          start <= 1'b0;
        end else begin
          in_data <= head.item;
          start   <= 1'b1;
          void'(blit_requests.pop_front());
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: check results, then predict the command transferred at this edge
  always @(posedge clk) begin : monitor
    out_item_t want;
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      if (out_valid) begin
        results_checked++;
        if (expected_replies.size() == 0) begin
          report_mismatch($sformatf("result with none pending: read_data %h data_valid %b",
                                    out_data.read_data, out_data.data_valid));
        end else begin
          want = expected_replies.pop_front();
          if (out_data.read_data !== want.read_data)
            report_mismatch($sformatf("read_data got %h expected %h",
                                      out_data.read_data, want.read_data));
          if (out_data.data_valid !== want.data_valid)
            report_mismatch($sformatf("data_valid got %b expected %b",
                                      out_data.data_valid, want.data_valid));
        end
      end
      if (start && !busy) begin
        expected_replies.push_back(predict_blit(in_data));
        cmd_count[in_data.cmd]++;
      end
      in_taken <= start && !busy;
    end
  end

  // watchdog on cycles without a command transfer or a result
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", idle_cycles);
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // stimulus and end of run
  initial begin : main
    int unsigned ready [$];
    int unsigned roll;
    int unsigned slot;
    int unsigned x;
    int unsigned y;
    int unsigned phase;
    int unsigned next_phase_at;
    gen_count    = 0;
    gen_idle_pct = IDLE_PCT[0];

    // the framebuffer is undefined until cleared, so a clear goes first
    queue_clear(1'b0, 1'b0);
    queue_slot_fill(0);

    // directed: extremes, every command, edge and buffer-end cases
    queue_read(0);
    queue_read(FB_TOTAL - 1);
    queue_load(0, 0, '1, '0);
    queue_load(0, SPR_WORDS - 1, '0, '1);
    queue_load(0, SPR_WORDS, '1, '1);
    queue_load(0, FB_TOTAL - 1, '1, '1);
    queue_draw(0, 0, 0);
    queue_read(0);
    queue_read(1);
    queue_read(FB_WX);
    // right edge wraps onto the next line
    queue_draw(0, 511, 0);
    queue_read(FB_WX - 1);
    queue_read(FB_WX);
    queue_read(2 * FB_WX);
    // past the buffer end the writes are dropped
    queue_draw(0, 505, 255);
    queue_read(FB_TOTAL - 1);
    queue_read(FB_TOTAL - FB_WX);
    queue_draw(0, 7, 100);
    queue_read(100 * FB_WX + 1);
    queue_clear(1'b1, 1'b1);
    queue_read(0);
    queue_draw(0, 16, 3);
    queue_read(3 * FB_WX + 1);

    // random: draws from fully loaded slots, each followed by reads around it, mixed with reads, loads and clears
    phase         = 0;
    next_phase_at = gen_count + PHASE_LEN;
    while (gen_count < RANDOM_ITEMS) begin
      if (gen_count >= next_phase_at) begin
        phase++;
        gen_idle_pct  = IDLE_PCT[phase % 3];
        next_phase_at = gen_count + PHASE_LEN;
      end
      ready.delete();
      for (int unsigned s = 0; s < SLOTS; s++) if (slot_ready(s)) ready.push_back(s);
      roll = $urandom_range(99);
      if (ready.size() < 3 || roll < 1) begin
        queue_slot_fill($urandom_range(SLOTS - 1));
      end else if (roll < 50) begin
        slot = ready[$urandom_range(ready.size() - 1)];
        x    = $urandom_range(511);
        if ($urandom_range(3) == 0) x = x & ~32'd15;
        y    = $urandom_range(255);
        queue_draw(slot, x, y);
        repeat ($urandom_range(3, 1))
          queue_read(y * FB_WX + (x >> SHIFT_W) + $urandom_range(SPR_LINES - 1) * FB_WX +
                     $urandom_range(SPR_WX));
      end else if (roll < 68) begin
        queue_read($urandom_range(FB_TOTAL - 1));
      end else if (roll < 90) begin
        if ($urandom_range(99) < 85)
          queue_load($urandom_range(SLOTS - 1), $urandom_range(SPR_WORDS - 1),
                     WORD_W'($urandom), WORD_W'($urandom));
        else
          queue_load($urandom_range(SLOTS - 1), $urandom_range(FB_TOTAL - 1, SPR_WORDS),
                     WORD_W'($urandom), WORD_W'($urandom));
      end else if (roll < 93) begin
        queue_clear(1'($urandom_range(1)), 1'($urandom_range(1)));
      end else begin
        // hold off until every owed result has come
        queue_read($urandom_range(FB_TOTAL - 1), 1'b1);
      end
    end

    // reset, then let the driver run the queue
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    while (blit_requests.size() != 0 || start || expected_replies.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_replies.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_replies.size()));

    $display("covered %0d loads, %0d clears, %0d draws, %0d reads; %0d results checked",
             cmd_count[CMD_LOAD], cmd_count[CMD_CLEAR], cmd_count[CMD_DRAW],
             cmd_count[CMD_READ], results_checked);
    $display("draws at aligned, shifted, wrapping and clipped positions, sender gaps 0/54/9");
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches", error_count);
      $display("FAILURE");
    end
    $finish;
  end

endmodule
